>>> rtl/cluster_outlier_trim_and_side_sign_unit_assert.svh
// assertion macros for the cluster outlier trim and side sign unit
`ifndef CLUSTER_OUTLIER_TRIM_AND_SIDE_SIGN_UNIT_ASSERT_SVH
`define CLUSTER_OUTLIER_TRIM_AND_SIDE_SIGN_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define COTSS_ASSERT_IMPL(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define COTSS_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cotss_pkg.sv
// types and constants shared by the cluster outlier trim and side sign unit
package cotss_pkg;

   localparam int POS_W           = 23;
   localparam int CUT_W           = 20;
   localparam int CSR_IDX_W       = 2;
   localparam int AMB_W           = 3;
   localparam int HIT_INDEX_W     = 4;
   localparam int REMOVED_COUNT_W = 5;
   localparam int SIGNS_COUNT_W   = 2;
   localparam int REQ_DATA_W      = 24;
   localparam int RSP_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_CUT       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGN_CUT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_OUTLIER = 2'd2;

   localparam logic [CUT_W-1:0] WIDE_CUT_RESET = 20'd5000;
   localparam logic [CUT_W-1:0] SIGN_CUT_RESET = 20'd2500;

   localparam logic [AMB_W-1:0] AMB_ZERO = 3'b000;
   localparam logic [AMB_W-1:0] AMB_POS  = 3'b010;
   localparam logic [AMB_W-1:0] AMB_NEG  = 3'b110;

   localparam logic [SIGNS_COUNT_W-1:0] SIGNS_NONE  = 2'd0;
   localparam logic [SIGNS_COUNT_W-1:0] SIGNS_FIXED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DECIDE,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/cotss_scan_unit.sv
// shared min, max and sum accumulator used by every trimming pass
module cotss_scan_unit #(
   parameter int MAX_HITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic                                   sample,
   input  logic signed [cotss_pkg::POS_W-1:0]     pos,
   input  logic                                   dir,
   input  logic [$clog2(MAX_HITS)-1:0]            idx,
   output logic signed [cotss_pkg::POS_W-1:0]     min_pos,
   output logic                                   min_dir,
   output logic [$clog2(MAX_HITS)-1:0]            min_idx,
   output logic signed [cotss_pkg::POS_W-1:0]     max_pos,
   output logic                                   max_dir,
   output logic [$clog2(MAX_HITS)-1:0]            max_idx,
   output logic signed [cotss_pkg::POS_W+$clog2(MAX_HITS+1)-1:0] sum,
   output logic [$clog2(MAX_HITS+1)-1:0]          num
);

   localparam int IW = $clog2(MAX_HITS);
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int SW = cotss_pkg::POS_W + CW;

   logic signed [cotss_pkg::POS_W-1:0] min_pos_ff, min_pos_in, max_pos_ff, max_pos_in;
   logic                               min_dir_ff, min_dir_in, max_dir_ff, max_dir_in;
   logic [IW-1:0]                      min_idx_ff, min_idx_in, max_idx_ff, max_idx_in;
   logic signed [SW-1:0]               sum_ff, sum_in;
   logic [CW-1:0]                      num_ff, num_in;

   always_comb begin
      min_pos_in = min_pos_ff;
      min_dir_in = min_dir_ff;
      min_idx_in = min_idx_ff;
      max_pos_in = max_pos_ff;
      max_dir_in = max_dir_ff;
      max_idx_in = max_idx_ff;
      sum_in     = sum_ff;
      num_in     = num_ff;
      if (clear) begin
         sum_in = '0;
         num_in = '0;
      end else if (sample) begin
         // strict compares keep the first index on ties
         if (num_ff == '0 || pos < min_pos_ff) begin
            min_pos_in = pos;
            min_dir_in = dir;
            min_idx_in = idx;
         end
         if (num_ff == '0 || pos > max_pos_ff) begin
            max_pos_in = pos;
            max_dir_in = dir;
            max_idx_in = idx;
         end
         sum_in = sum_ff + SW'(pos);
         num_in = num_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else begin
         num_ff <= num_in;
      end
      min_pos_ff <= min_pos_in;
      min_dir_ff <= min_dir_in;
      min_idx_ff <= min_idx_in;
      max_pos_ff <= max_pos_in;
      max_dir_ff <= max_dir_in;
      max_idx_ff <= max_idx_in;
      sum_ff     <= sum_in;
   end

   assign min_pos = min_pos_ff;
   assign min_dir = min_dir_ff;
   assign min_idx = min_idx_ff;
   assign max_pos = max_pos_ff;
   assign max_dir = max_dir_ff;
   assign max_idx = max_idx_ff;
   assign sum     = sum_ff;
   assign num     = num_ff;

endmodule

>>> rtl/cluster_outlier_trim_and_side_sign_unit.sv
// Cluster outlier trim and side sign unit. Hit words are taken one per cycle
// into a hit memory until the word with tlast; the unit then stops taking words
// and trims the cluster with one shared min/max/sum accumulator. Each trimming
// pass reads the stored hits one a cycle from the memory through a registered
// read port, then takes a multiply step and a decide step; a cluster needs one
// pass plus one per hit removed singly. Then one result word per stored hit
// leaves at up to one a cycle, and the unit takes hit words again. Hits beyond
// MAX_HITS are dropped; their tlast still closes the cluster.
`include "cluster_outlier_trim_and_side_sign_unit_assert.svh"

module cluster_outlier_trim_and_side_sign_unit #(
   parameter int MAX_HITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // hit words
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [cotss_pkg::REQ_DATA_W-1:0]         req_tdata,  // position, dir_positive
   input  logic                                     req_tlast,
   // result words
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // hit_index, removed, mark_outlier, ambiguity, removed_count, signs_set_count
   output logic [cotss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tlast,
   // register writes
   input  logic                                     csr_we,
   input  logic [cotss_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [cotss_pkg::CUT_W-1:0]              csr_wdata
);

   localparam int IW = $clog2(MAX_HITS);
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int SW = cotss_pkg::POS_W + CW;
   localparam int DW = cotss_pkg::POS_W + CW + 2;
   localparam int PW = cotss_pkg::POS_W + 2;

   cotss_pkg::state_type state_ff, state_in;

   logic [cotss_pkg::CUT_W-1:0] wide_cut_ff, sign_cut_ff;
   logic                        remove_ff;

   logic [cotss_pkg::REQ_DATA_W-1:0] hit_mem [MAX_HITS];
   logic [cotss_pkg::REQ_DATA_W-1:0] rd_word_ff;
   logic                             mem_we;
   logic [IW-1:0]                    mem_waddr, mem_raddr;

   logic [CW-1:0]       count_ff, count_in;
   logic [MAX_HITS-1:0] active_ff, active_in;
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]       pipe_idx_ff;
   logic [CW-1:0]       removed_ff, removed_in;
   logic                signs_set_ff, signs_set_in;
   logic [IW-1:0]       amb_min_idx_ff, amb_min_idx_in, amb_max_idx_ff, amb_max_idx_in;
   logic [cotss_pkg::AMB_W-1:0] amb_min_val_ff, amb_min_val_in;
   logic [cotss_pkg::AMB_W-1:0] amb_max_val_ff, amb_max_val_in;
   logic signed [DW-1:0] prod_min_ff, prod_min_in, prod_max_ff, prod_max_in;
   logic signed [PW-1:0] spread_ff, spread_in;
   logic [CW-1:0]        emit_idx_ff, emit_idx_in;

   logic                              rsp_vld_ff, rsp_vld_in, rsp_last_ff, rsp_last_in;
   logic [cotss_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                               sc_clear, sc_sample;
   logic signed [cotss_pkg::POS_W-1:0] sc_min_pos, sc_max_pos;
   logic                               sc_min_dir, sc_max_dir;
   logic [IW-1:0]                      sc_min_idx, sc_max_idx;
   logic signed [SW-1:0]               sc_sum;
   logic [CW-1:0]                      sc_num;

   logic signed [DW-1:0] d_min, d_max;
   logic                 req_take, rsp_load, gone, mark, emit_last;
   logic [cotss_pkg::AMB_W-1:0] amb_out;

   cotss_scan_unit #(
      .MAX_HITS(MAX_HITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .clear   (sc_clear),
      .sample  (sc_sample),
      .pos     (rd_word_ff[cotss_pkg::POS_W-1:0]),
      .dir     (rd_word_ff[cotss_pkg::POS_W]),
      .idx     (pipe_idx_ff),
      .min_pos (sc_min_pos),
      .min_dir (sc_min_dir),
      .min_idx (sc_min_idx),
      .max_pos (sc_max_pos),
      .max_dir (sc_max_dir),
      .max_idx (sc_max_idx),
      .sum     (sc_sum),
      .num     (sc_num)
   );

   assign sc_sample = pipe_vld_ff && active_ff[pipe_idx_ff];
   assign req_take  = req_tvalid && req_tready;
   assign mem_raddr = scan_idx_ff[IW-1:0];
   assign mem_waddr = count_ff[IW-1:0];
   assign d_min     = DW'(sc_sum) - prod_min_ff;
   assign d_max     = prod_max_ff - DW'(sc_sum);

   // result word fields
   assign gone      = !active_ff[emit_idx_ff[IW-1:0]];
   assign mark      = (removed_ff != '0) && remove_ff && (count_ff > CW'(2));
   assign emit_last = (emit_idx_ff + CW'(1)) == count_ff;
   always_comb begin
      priority if (signs_set_ff && emit_idx_ff[IW-1:0] == amb_max_idx_ff) begin
         amb_out = amb_max_val_ff;
      end else if (signs_set_ff && emit_idx_ff[IW-1:0] == amb_min_idx_ff) begin
         amb_out = amb_min_val_ff;
      end else begin
         amb_out = cotss_pkg::AMB_ZERO;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      active_in      = active_ff;
      scan_idx_in    = scan_idx_ff;
      pipe_vld_in    = 1'b0;
      removed_in     = removed_ff;
      signs_set_in   = signs_set_ff;
      amb_min_idx_in = amb_min_idx_ff;
      amb_max_idx_in = amb_max_idx_ff;
      amb_min_val_in = amb_min_val_ff;
      amb_max_val_in = amb_max_val_ff;
      prod_min_in    = prod_min_ff;
      prod_max_in    = prod_max_ff;
      spread_in      = spread_ff;
      emit_idx_in    = '0;
      sc_clear       = 1'b0;
      mem_we         = 1'b0;
      req_tready     = 1'b0;
      rsp_load       = 1'b0;

      unique case (state_ff)
         cotss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               if (count_ff < CW'(MAX_HITS)) begin
                  mem_we               = 1'b1;
                  active_in[mem_waddr] = 1'b1;
                  count_in             = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  removed_in   = '0;
                  signs_set_in = 1'b0;
                  scan_idx_in  = '0;
                  sc_clear     = 1'b1;
                  if (count_in >= CW'(2)) begin
                     state_in = cotss_pkg::ST_SCAN;
                  end else begin
                     state_in = cotss_pkg::ST_EMIT;
                  end
               end
            end
         end
         cotss_pkg::ST_SCAN: begin
            if (scan_idx_ff < count_ff) begin
               pipe_vld_in = 1'b1;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else if (!pipe_vld_ff) begin
               if (sc_num <= CW'(1)) begin
                  state_in = cotss_pkg::ST_EMIT;
               end else begin
                  state_in = cotss_pkg::ST_MUL;
               end
            end
         end
         cotss_pkg::ST_MUL: begin
            prod_min_in = DW'($signed({1'b0, sc_num})) * DW'(sc_min_pos);
            prod_max_in = DW'($signed({1'b0, sc_num})) * DW'(sc_max_pos);
            spread_in   = PW'(sc_max_pos) - PW'(sc_min_pos);
            state_in    = cotss_pkg::ST_DECIDE;
         end
         cotss_pkg::ST_DECIDE: begin
            priority if (spread_ff > $signed({5'b0, wide_cut_ff})) begin
               if (sc_num == CW'(2)) begin
                  active_in[sc_min_idx] = 1'b0;
                  active_in[sc_max_idx] = 1'b0;
                  removed_in            = removed_ff + CW'(2);
                  state_in              = cotss_pkg::ST_EMIT;
               end else begin
                  if (d_min > d_max) begin
                     active_in[sc_min_idx] = 1'b0;
                  end else begin
                     active_in[sc_max_idx] = 1'b0;
                  end
                  removed_in  = removed_ff + CW'(1);
                  scan_idx_in = '0;
                  sc_clear    = 1'b1;
                  state_in    = cotss_pkg::ST_SCAN;
               end
            end else if (spread_ff > $signed({5'b0, sign_cut_ff})) begin
               signs_set_in   = 1'b1;
               amb_max_idx_in = sc_max_idx;
               amb_min_idx_in = sc_min_idx;
               amb_max_val_in = sc_max_dir ? cotss_pkg::AMB_POS : cotss_pkg::AMB_NEG;
               amb_min_val_in = sc_min_dir ? cotss_pkg::AMB_NEG : cotss_pkg::AMB_POS;
               state_in       = cotss_pkg::ST_EMIT;
            end else begin
               state_in = cotss_pkg::ST_EMIT;
            end
         end
         cotss_pkg::ST_EMIT: begin
            emit_idx_in = emit_idx_ff;
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_load    = 1'b1;
               emit_idx_in = emit_idx_ff + CW'(1);
               if (emit_last) begin
                  active_in = '0;
                  count_in  = '0;
                  state_in  = cotss_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cotss_pkg::ST_IDLE;
         end
      endcase
   end

   // output stage
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_last_in = emit_last;
         rsp_data_in = {
            signs_set_ff ? cotss_pkg::SIGNS_FIXED : cotss_pkg::SIGNS_NONE,
            cotss_pkg::REMOVED_COUNT_W'(removed_ff),
            amb_out,
            gone && mark,
            gone,
            cotss_pkg::HIT_INDEX_W'(emit_idx_ff)
         };
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hit_mem[mem_waddr] <= req_tdata;
      end
      rd_word_ff <= hit_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cotss_pkg::ST_IDLE;
         count_ff     <= '0;
         active_ff    <= '0;
         pipe_vld_ff  <= 1'b0;
         removed_ff   <= '0;
         signs_set_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         wide_cut_ff  <= cotss_pkg::WIDE_CUT_RESET;
         sign_cut_ff  <= cotss_pkg::SIGN_CUT_RESET;
         remove_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         pipe_vld_ff  <= pipe_vld_in;
         removed_ff   <= removed_in;
         signs_set_ff <= signs_set_in;
         rsp_vld_ff   <= rsp_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               cotss_pkg::CSR_WIDE_CUT:       wide_cut_ff <= csr_wdata;
               cotss_pkg::CSR_SIGN_CUT:       sign_cut_ff <= csr_wdata;
               cotss_pkg::CSR_REMOVE_OUTLIER: remove_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      scan_idx_ff    <= scan_idx_in;
      pipe_idx_ff    <= scan_idx_ff[IW-1:0];
      amb_min_idx_ff <= amb_min_idx_in;
      amb_max_idx_ff <= amb_max_idx_in;
      amb_min_val_ff <= amb_min_val_in;
      amb_max_val_ff <= amb_max_val_in;
      prod_min_ff    <= prod_min_in;
      prod_max_ff    <= prod_max_in;
      spread_ff      <= spread_in;
      emit_idx_ff    <= emit_idx_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `COTSS_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(MAX_HITS), "hit count overflow")
   `COTSS_ASSERT_IMPL(a_active_in_range, 1'b1, (active_ff >> count_ff) == '0, "stray active hit")
   `COTSS_ASSERT_IMPL(a_removed_bound, state_ff == cotss_pkg::ST_EMIT, removed_ff <= count_ff, "removed above count")
   `COTSS_ASSERT_NEXT(a_signs_distinct, state_ff == cotss_pkg::ST_DECIDE && !signs_set_ff && signs_set_in, amb_min_idx_ff != amb_max_idx_ff, "min and max share a hit")

endmodule
